/* rtl/mprr_pkg.sv */
// ----------------------------------------------------------------------------
// MED predictor residual package
// Shared types and constants for the RGB median edge detector residual block.
// ----------------------------------------------------------------------------
package mprr_pkg;

  // Field widths of the pixel and result transactions.
  localparam int unsigned ChanW      = 8;
  localparam int unsigned PixW       = 3 * ChanW;
  localparam int unsigned ImageWidthW = 11;

  // Configuration port widths.
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 11;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    RegImageWidth  = 8'd0,
    RegBorderRed   = 8'd1,
    RegBorderGreen = 8'd2,
    RegBorderBlue  = 8'd3
  } cfg_reg_e;

  // Reset value of the row width register.
  localparam logic [ImageWidthW-1:0] ImageWidthReset = 11'd1024;

  // Current configuration as seen by the datapath.
  typedef struct packed {
    logic [ImageWidthW-1:0] image_width;
    logic [ChanW-1:0]       border_red;
    logic [ChanW-1:0]       border_green;
    logic [ChanW-1:0]       border_blue;
  } cfg_t;

  // Position flags of one pixel within the raster.
  typedef struct packed {
    logic first_row;
    logic col_zero;
    logic end_of_row;
  } raster_t;

endpackage

/* rtl/mprr_if.sv */
// ----------------------------------------------------------------------------
// MED predictor residual channel interfaces
// Valid/ready channels for pixels, residuals and configuration writes.
// ----------------------------------------------------------------------------

// Pixel input channel.
interface mprr_pix_if;
  logic                        valid;
  logic                        ready;
  logic [mprr_pkg::ChanW-1:0]  pixel_red;
  logic [mprr_pkg::ChanW-1:0]  pixel_green;
  logic [mprr_pkg::ChanW-1:0]  pixel_blue;
  logic                        start_of_image;

  modport source (
    output valid, pixel_red, pixel_green, pixel_blue, start_of_image,
    input  ready
  );
  modport sink (
    input  valid, pixel_red, pixel_green, pixel_blue, start_of_image,
    output ready
  );
endinterface

// Residual output channel.
interface mprr_res_if;
  logic                        valid;
  logic                        ready;
  logic [mprr_pkg::ChanW-1:0]  residual_red;
  logic [mprr_pkg::ChanW-1:0]  residual_green;
  logic [mprr_pkg::ChanW-1:0]  residual_blue;
  logic                        end_of_row;

  modport source (
    output valid, residual_red, residual_green, residual_blue, end_of_row,
    input  ready
  );
  modport sink (
    input  valid, residual_red, residual_green, residual_blue, end_of_row,
    output ready
  );
endinterface

// Configuration write channel.
interface mprr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mprr_pkg::CfgIdxW-1:0]  index;
  logic [mprr_pkg::CfgDataW-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

/* rtl/med_predictor_residual_rgb_core.sv */
// ----------------------------------------------------------------------------
// MED predictor residual RGB core
// JPEG-LS style median edge detector residuals for a raster RGB stream.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on pix_i in raster order, one transaction per pixel; a set
//   start_of_image restarts the row and column count. Each pixel yields one
//   transaction on res_o with the three residuals (value minus prediction,
//   modulo 256) and an end_of_row flag on the last pixel of each row.
//   Configuration writes on cfg_i are always taken; index 0: row width, 1 to 3
//   the border color. The user, not the block, ensures no pixel is in flight.
// Timing:
//   A pixel accepted on pix_i passes the input stage registers and then the
//   output register before it is shown on res_o. The block takes one pixel
//   per cycle while res_o does not stall: the line buffer is read and written
//   at the same address in the cycle of acceptance, and the prediction sits
//   between that read register and the output register.
// Reset and stalls:
//   Reset clears the scan position to the first pixel of an image and loads
//   a width of 1024 and a black border. The line buffer needs no clearing.
//   When res_o stalls, the two stages fill and then pix_i.ready drops.
// ----------------------------------------------------------------------------
module med_predictor_residual_rgb_core #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mprr_pix_if.sink   pix_i,
  mprr_res_if.source res_o,
  mprr_cfg_if.sink   cfg_i
);

  localparam int unsigned IdxW  = $clog2(MAX_WIDTH);
  localparam int unsigned ChanW = mprr_pkg::ChanW;
  localparam int unsigned PixW  = mprr_pkg::PixW;

  mprr_pkg::cfg_t    cfg;
  mprr_pkg::raster_t raster, s1_raster_q;

  logic              accept, s1_adv;
  logic              s1_valid_q, s1_valid_d, out_valid_q, out_valid_d;
  logic [IdxW-1:0]   col;
  logic [PixW-1:0]   pixel, west_prev, row_rdata;
  logic [PixW-1:0]   s1_pixel_q, s1_west_q, nw_q;
  logic [PixW-1:0]   border, north, west, nw, residual;
  logic [PixW-1:0]   res_q;
  logic              eor_q;

  // Configuration register file.
  mprr_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Pipeline handshake: the input stage moves on when the output is free.
  assign s1_adv      = s1_valid_q && (!out_valid_q || res_o.ready);
  assign pix_i.ready = !s1_valid_q || s1_adv;
  assign accept      = pix_i.valid && pix_i.ready;
  assign pixel       = {pix_i.pixel_red, pix_i.pixel_green, pix_i.pixel_blue};

  // Scan position and west neighbor.
  mprr_raster_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .IdxW      (IdxW)
  ) u_raster (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .start_i       (pix_i.start_of_image),
    .pixel_i       (pixel),
    .image_width_i (cfg.image_width),
    .col_o         (col),
    .raster_o      (raster),
    .west_o        (west_prev)
  );

  // Previous row; its read data is the north neighbor in the next cycle.
  mprr_line_buffer #(
    .DEPTH (MAX_WIDTH),
    .AW    (IdxW)
  ) u_line (
    .clk_i   (clk_i),
    .en_i    (accept),
    .addr_i  (col),
    .wdata_i (pixel),
    .rdata_o (row_rdata)
  );

  // Input stage registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pixel_q  <= pixel;
      s1_west_q   <= west_prev;
      s1_raster_q <= raster;
    end
  end

  // Neighbor selection with the border outside the image.
  assign border = {cfg.border_red, cfg.border_green, cfg.border_blue};
  assign north  = s1_raster_q.first_row ? border : row_rdata;
  assign west   = s1_raster_q.col_zero ? border : s1_west_q;
  assign nw     = (s1_raster_q.first_row || s1_raster_q.col_zero) ? border : nw_q;

  // The north neighbor of this pixel is the northwest one of the next.
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      nw_q <= north;
    end
  end

  // One predictor per color channel.
  for (genvar k = 0; k < 3; k++) begin : g_chan
    mprr_med_channel u_med (
      .x_i        (s1_pixel_q[k*ChanW +: ChanW]),
      .west_i     (west[k*ChanW +: ChanW]),
      .north_i    (north[k*ChanW +: ChanW]),
      .nw_i       (nw[k*ChanW +: ChanW]),
      .residual_o (residual[k*ChanW +: ChanW])
    );
  end

  // Valid bits of both stages.
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_q <= residual;
      eor_q <= s1_raster_q.end_of_row;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.residual_red   = res_q[2*ChanW +: ChanW];
  assign res_o.residual_green = res_q[ChanW +: ChanW];
  assign res_o.residual_blue  = res_q[0 +: ChanW];
  assign res_o.end_of_row     = eor_q;

`ifndef SYNTHESIS
  // A pixel taken in always occupies the input stage next.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_i.valid && pix_i.ready |=> s1_valid_q)
    else $error("accepted pixel lost from input stage");

  // An empty input stage never refuses a pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> pix_i.ready)
    else $error("input refused while pipeline empty");

  // With the output stalled, the waiting pixel stays in the input stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !res_o.ready |=> s1_valid_q && out_valid_q)
    else $error("pipeline dropped a pixel under stall");
`endif

endmodule

/* rtl/mprr_cfg_regs.sv */
// ----------------------------------------------------------------------------
// MED predictor residual configuration registers
// Decodes configuration write transactions into the register file.
// ----------------------------------------------------------------------------
module mprr_cfg_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  mprr_cfg_if.sink         cfg_i,
  output mprr_pkg::cfg_t   cfg_o
);

  mprr_pkg::cfg_t cfg_q, cfg_d;

  // Writes are always taken.
  assign cfg_i.ready = 1'b1;

  // Register decode; unknown indexes are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (mprr_pkg::cfg_reg_e'(cfg_i.index))
        mprr_pkg::RegImageWidth:  cfg_d.image_width  = cfg_i.data;
        mprr_pkg::RegBorderRed:   cfg_d.border_red   = cfg_i.data[mprr_pkg::ChanW-1:0];
        mprr_pkg::RegBorderGreen: cfg_d.border_green = cfg_i.data[mprr_pkg::ChanW-1:0];
        mprr_pkg::RegBorderBlue:  cfg_d.border_blue  = cfg_i.data[mprr_pkg::ChanW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= mprr_pkg::ImageWidthReset;
      cfg_q.border_red   <= '0;
      cfg_q.border_green <= '0;
      cfg_q.border_blue  <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/mprr_raster_ctrl.sv */
// ----------------------------------------------------------------------------
// MED predictor residual raster control
// Tracks column, first row and the previous pixel of the raster scan.
// ----------------------------------------------------------------------------
module mprr_raster_ctrl #(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned IdxW      = $clog2(MAX_WIDTH)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  logic                                start_i,
  input  logic [mprr_pkg::PixW-1:0]           pixel_i,
  input  logic [mprr_pkg::ImageWidthW-1:0]    image_width_i,
  output logic [IdxW-1:0]                     col_o,
  output mprr_pkg::raster_t                   raster_o,
  output logic [mprr_pkg::PixW-1:0]           west_o
);

  localparam int unsigned CntW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CmpW =
    (CntW > mprr_pkg::ImageWidthW) ? CntW : mprr_pkg::ImageWidthW;

  logic [IdxW-1:0]            col_q, col_d, col_cur;
  logic                       first_q, first_d, first_cur;
  logic [mprr_pkg::PixW-1:0]  west_q;
  logic [CmpW-1:0]            width_ext, width_eff, col_next_ext;
  logic                       eor;

  // Clamp the configured width into the supported range.
  always_comb begin
    width_ext = CmpW'(image_width_i);
    if (width_ext == '0) begin
      width_eff = CmpW'(1);
    end else if (width_ext > CmpW'(MAX_WIDTH)) begin
      width_eff = CmpW'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end
  end

  // Position of the pixel now offered; a start mark restarts the image.
  assign col_cur      = start_i ? '0 : col_q;
  assign first_cur    = start_i | first_q;
  assign col_next_ext = CmpW'(col_cur) + CmpW'(1);
  assign eor          = (col_next_ext >= width_eff);

  // Advance the scan position on each accepted transaction.
  always_comb begin
    col_d   = col_q;
    first_d = first_q;
    if (accept_i) begin
      if (eor) begin
        col_d   = '0;
        first_d = 1'b0;
      end else begin
        col_d   = col_cur + IdxW'(1);
        first_d = first_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      first_q <= 1'b1;
    end else begin
      col_q   <= col_d;
      first_q <= first_d;
    end
  end

  // The previous pixel becomes the west neighbor of the next one.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      west_q <= pixel_i;
    end
  end

  assign col_o               = col_cur;
  assign raster_o.first_row  = first_cur;
  assign raster_o.col_zero   = (col_cur == '0);
  assign raster_o.end_of_row = eor;
  assign west_o              = west_q;

`ifndef SYNTHESIS
  // The column always stays inside the line buffer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    CntW'(col_q) < CntW'(MAX_WIDTH))
    else $error("column index out of range");

  // The last pixel of a row returns the scan to column zero of a later row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && eor |=> (col_q == '0) && !first_q)
    else $error("row end did not wrap the column");
`endif

endmodule

/* rtl/mprr_line_buffer.sv */
// ----------------------------------------------------------------------------
// MED predictor residual line buffer
// One row of pixels; read of the old entry and write of the new in the same cycle.
// ----------------------------------------------------------------------------
module mprr_line_buffer #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [AW-1:0]              addr_i,
  input  logic [mprr_pkg::PixW-1:0]  wdata_i,
  output logic [mprr_pkg::PixW-1:0]  rdata_o
);

  logic [mprr_pkg::PixW-1:0] mem_q [DEPTH];
  logic [mprr_pkg::PixW-1:0] rdata_q;

  // The read returns the entry of the row above before it is replaced.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mem_q[addr_i] <= wdata_i;
      rdata_q       <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/mprr_med_channel.sv */
// ----------------------------------------------------------------------------
// MED predictor residual channel
// Median edge detector prediction and modulo-256 residual for one channel.
// ----------------------------------------------------------------------------
module mprr_med_channel (
  input  logic [mprr_pkg::ChanW-1:0] x_i,
  input  logic [mprr_pkg::ChanW-1:0] west_i,
  input  logic [mprr_pkg::ChanW-1:0] north_i,
  input  logic [mprr_pkg::ChanW-1:0] nw_i,
  output logic [mprr_pkg::ChanW-1:0] residual_o
);

  logic [mprr_pkg::ChanW-1:0] hi, lo, pred;
  logic [mprr_pkg::ChanW+1:0] grad;

  assign hi   = (west_i > north_i) ? west_i : north_i;
  assign lo   = (west_i > north_i) ? north_i : west_i;
  assign grad = {2'b00, west_i} + {2'b00, north_i} - {2'b00, nw_i};

  // An edge picks the smaller or larger neighbor, flat areas the gradient.
  always_comb begin
    if (nw_i >= hi) begin
      pred = lo;
    end else if (nw_i <= lo) begin
      pred = hi;
    end else begin
      pred = grad[mprr_pkg::ChanW-1:0];
    end
  end

  assign residual_o = x_i - pred;

endmodule
